FILE: hdl/failsafe_mode_gate_core_macros.svh
// ---------------------------------------------------------------------------
// failsafe_mode_gate_core_macros.svh
// Assertion macros shared by the failsafe gate checkers.
// ---------------------------------------------------------------------------
`ifndef FAILSAFE_MODE_GATE_CORE_MACROS_SVH
`define FAILSAFE_MODE_GATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FMG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fmg_pkg.sv
// ---------------------------------------------------------------------------
// fmg_pkg
// Types, codes and register defaults of the failsafe mode gate.
// ---------------------------------------------------------------------------
package fmg_pkg;

	// Robot mode
	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_TELEOP   = 2'd1,
		MODE_AUTO     = 2'd2,
		MODE_FAULT    = 2'd3
	} mode_t;

	// Reason code reported with every result
	typedef enum logic [3:0] {
		RSN_NONE     = 4'd0,
		RSN_SELFTEST = 4'd1,
		RSN_MOTOR_L  = 4'd2,
		RSN_MOTOR_R  = 4'd3,
		RSN_SAG      = 4'd4,
		RSN_OVERRUN  = 4'd5,
		RSN_NOLINK   = 4'd6,
		RSN_LINKLOST = 4'd7,
		RSN_DISABLED = 4'd8
	} reason_t;

	// Commands
	localparam logic [1:0] CMD_EVAL     = 2'd0;
	localparam logic [1:0] CMD_SELFTEST = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_CUTOFF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAG_DEBOUNCE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN_COUNT  = 3'd4;

	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic [15:0] DEF_BATTERY_CUTOFF = 16'd6000;
	localparam logic [15:0] DEF_LINK_TIMEOUT   = 16'd500;
	localparam logic [15:0] DEF_SAG_DEBOUNCE   = 16'd500;
	localparam logic [15:0] DEF_OVERRUN_LIMIT  = 16'd11000;
	localparam logic [7:0]  DEF_OVERRUN_COUNT  = 8'd5;

	// One input item
	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] now_ms;
		logic        link_never;
		logic [15:0] link_age_ms;
		logic        enable_switch;
		logic        auto_switch;
		logic        motor_fault_left;
		logic        motor_fault_right;
		logic        battery_valid;
		logic [15:0] battery_mv;
		logic [15:0] cycle_time_us;
		logic        self_test_passed;
	} item_t;

	// One result item
	typedef struct packed {
		mode_t   mode;
		reason_t reason;
		logic    fault_latched;
	} result_t;

	// Configuration register set
	typedef struct packed {
		logic [15:0] battery_cutoff_mv;
		logic [15:0] link_timeout_ms;
		logic [15:0] sag_debounce_ms;
		logic [15:0] overrun_limit_us;
		logic [7:0]  overrun_fault_count;
	} cfg_t;

endpackage

FILE: hdl/fmg_if.sv
// ---------------------------------------------------------------------------
// fmg_if
// Valid/ready channels of the failsafe mode gate: input items, results and
// configuration writes.
// ---------------------------------------------------------------------------

// Input item channel
interface fmg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] now_ms;
	logic        link_never;
	logic [15:0] link_age_ms;
	logic        enable_switch;
	logic        auto_switch;
	logic        motor_fault_left;
	logic        motor_fault_right;
	logic        battery_valid;
	logic [15:0] battery_mv;
	logic [15:0] cycle_time_us;
	logic        self_test_passed;

	modport source (
		output valid, command, now_ms, link_never, link_age_ms, enable_switch,
		       auto_switch, motor_fault_left, motor_fault_right, battery_valid,
		       battery_mv, cycle_time_us, self_test_passed,
		input  ready
	);
	modport sink (
		input  valid, command, now_ms, link_never, link_age_ms, enable_switch,
		       auto_switch, motor_fault_left, motor_fault_right, battery_valid,
		       battery_mv, cycle_time_us, self_test_passed,
		output ready
	);
endinterface

// Result channel
interface fmg_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [3:0] reason;
	logic       fault_latched;

	modport source (output valid, mode, reason, fault_latched, input ready);
	modport sink (input valid, mode, reason, fault_latched, output ready);
endinterface

// Configuration write channel
interface fmg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/fmg_cfg_regs.sv
// ---------------------------------------------------------------------------
// fmg_cfg_regs
// Configuration register file; one register written per transfer.
// ---------------------------------------------------------------------------
module fmg_cfg_regs
	import fmg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Writes never stall
	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register write decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_cutoff_mv   <= DEF_BATTERY_CUTOFF;
			cfg_q.link_timeout_ms     <= DEF_LINK_TIMEOUT;
			cfg_q.sag_debounce_ms     <= DEF_SAG_DEBOUNCE;
			cfg_q.overrun_limit_us    <= DEF_OVERRUN_LIMIT;
			cfg_q.overrun_fault_count <= DEF_OVERRUN_COUNT;
		end else if (wr_valid) begin
			unique case (wr_index)
				CFG_BATTERY_CUTOFF: cfg_q.battery_cutoff_mv   <= wr_data;
				CFG_LINK_TIMEOUT:   cfg_q.link_timeout_ms     <= wr_data;
				CFG_SAG_DEBOUNCE:   cfg_q.sag_debounce_ms     <= wr_data;
				CFG_OVERRUN_LIMIT:  cfg_q.overrun_limit_us    <= wr_data;
				CFG_OVERRUN_COUNT:  cfg_q.overrun_fault_count <= wr_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/fmg_eval.sv
// ---------------------------------------------------------------------------
// fmg_eval
// Gate state and the single-pass decision logic for one item.
// ---------------------------------------------------------------------------
module fmg_eval
	import fmg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	mode_t       mode_q, mode_n;
	logic        fault_q, fault_n;
	reason_t     reason_q, reason_n;
	logic        sag_active_q, sag_active_n;
	logic [31:0] sag_start_q, sag_start_n;
	logic [7:0]  run_q, run_n;

	reason_t     rsn;
	logic        sag_low, sag_hit, over, ovr_hit;
	logic [31:0] sag_elapsed;
	logic [7:0]  run_inc;

	// Sag and overrun detectors
	assign sag_low     = item.battery_valid && (item.battery_mv < cfg.battery_cutoff_mv);
	assign sag_elapsed = item.now_ms - sag_start_q;
	assign sag_hit     = sag_low && sag_active_q &&
	                     (sag_elapsed >= {16'd0, cfg.sag_debounce_ms});
	assign over        = item.cycle_time_us > cfg.overrun_limit_us;
	assign run_inc     = (run_q < cfg.overrun_fault_count) ? run_q + 8'd1 : run_q;
	assign ovr_hit     = over && (run_inc >= cfg.overrun_fault_count);

	// Next state and result
	always_comb begin
		mode_n       = mode_q;
		fault_n      = fault_q;
		reason_n     = reason_q;
		sag_active_n = sag_active_q;
		sag_start_n  = sag_start_q;
		run_n        = run_q;
		rsn          = RSN_NONE;

		case (item.command)
			CMD_EVAL: begin
				if (fault_q) begin
					// latched: timers stay frozen
					mode_n = MODE_FAULT;
					rsn    = reason_q;
				end else begin
					sag_active_n = sag_low;
					if (sag_low && !sag_active_q)
						sag_start_n = item.now_ms;
					run_n = over ? run_inc : 8'd0;

					if (item.motor_fault_left || item.motor_fault_right || sag_hit ||
					    ovr_hit) begin
						fault_n = 1'b1;
						mode_n  = MODE_FAULT;
						if (item.motor_fault_left)       reason_n = RSN_MOTOR_L;
						else if (item.motor_fault_right) reason_n = RSN_MOTOR_R;
						else if (sag_hit)                reason_n = RSN_SAG;
						else                             reason_n = RSN_OVERRUN;
						rsn = reason_n;
					end else if (item.link_never) begin
						mode_n = MODE_DISABLED;
						rsn    = RSN_NOLINK;
					end else if (item.link_age_ms > cfg.link_timeout_ms) begin
						mode_n = MODE_DISABLED;
						rsn    = RSN_LINKLOST;
					end else if (!item.enable_switch) begin
						mode_n = MODE_DISABLED;
						rsn    = RSN_DISABLED;
					end else if (mode_q == MODE_AUTO) begin
						mode_n = MODE_AUTO;
					end else if (mode_q == MODE_DISABLED && item.auto_switch) begin
						mode_n = MODE_AUTO;
					end else begin
						mode_n = MODE_TELEOP;
					end
				end
			end
			CMD_SELFTEST: begin
				// failed test forces fault; first reason is kept
				if (!item.self_test_passed) begin
					if (!fault_q) begin
						fault_n  = 1'b1;
						reason_n = RSN_SELFTEST;
					end
					mode_n = MODE_FAULT;
				end
				rsn = fault_n ? reason_n : RSN_NONE;
			end
			CMD_CLEAR: begin
				mode_n       = MODE_DISABLED;
				fault_n      = 1'b0;
				reason_n     = RSN_NONE;
				sag_active_n = 1'b0;
				sag_start_n  = 32'd0;
				run_n        = 8'd0;
			end
			default: begin
				rsn = fault_q ? reason_q : RSN_NONE;
			end
		endcase

		res.mode          = mode_n;
		res.reason        = rsn;
		res.fault_latched = fault_n;
	end

	// State registers, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_DISABLED;
			fault_q      <= 1'b0;
			reason_q     <= RSN_NONE;
			sag_active_q <= 1'b0;
			sag_start_q  <= 32'd0;
			run_q        <= 8'd0;
		end else if (advance) begin
			mode_q       <= mode_n;
			fault_q      <= fault_n;
			reason_q     <= reason_n;
			sag_active_q <= sag_active_n;
			sag_start_q  <= sag_start_n;
			run_q        <= run_n;
		end
	end

endmodule

FILE: hdl/failsafe_mode_gate_core.sv
// ---------------------------------------------------------------------------
// failsafe_mode_gate_core
// Per-control-cycle failsafe gate deciding the robot mode.
// ---------------------------------------------------------------------------
// Usage:
//   items   - one control-cycle event per transfer (evaluate, self-test
//             report or clear fault).
//   results - one result per item (mode, reason, fault latch), in order.
//   cfg     - register writes (index, data); always ready. Write only while
//             no item is in flight.
// Pipeline: the item transfer loads the input register, and the item moves
//   into the result register, raising results.valid, once that register is
//   free or drained.
// Throughput: one item per cycle while results are taken; the gate state is
//   updated in one pass of logic between the input and result registers.
// Stall: while results.ready is low the result register holds, one more
//   item waits in the input register, then items.ready drops.
// Reset: arst_n clears both pipeline stages, the mode (disabled), the fault
//   latch, the sag timer and overrun counter, and loads register defaults.
// ---------------------------------------------------------------------------
module failsafe_mode_gate_core
	import fmg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	fmg_in_if.sink     items,
	fmg_out_if.source  results,
	fmg_cfg_if.sink    cfg
);

	cfg_t    cfg_regs;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;
	result_t result_q;
	logic    out_valid_q;

	// Configuration registers
	fmg_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// Gather input payload
	always_comb begin
		item_in.command           = items.command;
		item_in.now_ms            = items.now_ms;
		item_in.link_never        = items.link_never;
		item_in.link_age_ms       = items.link_age_ms;
		item_in.enable_switch     = items.enable_switch;
		item_in.auto_switch       = items.auto_switch;
		item_in.motor_fault_left  = items.motor_fault_left;
		item_in.motor_fault_right = items.motor_fault_right;
		item_in.battery_valid     = items.battery_valid;
		item_in.battery_mv        = items.battery_mv;
		item_in.cycle_time_us     = items.cycle_time_us;
		item_in.self_test_passed  = items.self_test_passed;
	end

	// Stage 1 moves into the result register when that is free or drained
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= item_in;
		end
	end

	// Decision logic and gate state
	fmg_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_regs),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.mode          = result_q.mode;
	assign results.reason        = result_q.reason;
	assign results.fault_latched = result_q.fault_latched;

endmodule

FILE: hdl/fmg_checker.sv
// ---------------------------------------------------------------------------
// fmg_checker
// Port-level checks of the failsafe gate results, bound to the top level.
// ---------------------------------------------------------------------------
`include "failsafe_mode_gate_core_macros.svh"

module fmg_checker
	import fmg_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_mode,
	input logic [3:0] res_reason,
	input logic       res_fault
);

	// Stalled result holds
	`FMG_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_mode) && $stable(res_reason) && $stable(res_fault), "stalled result changed")

	// A latched fault always reports fault mode and a hard-fault reason
	`FMG_ASSERT_SAME(a_latch_mode, clk, arst_n, res_valid && res_fault, res_mode == MODE_FAULT && res_reason >= RSN_SELFTEST && res_reason <= RSN_OVERRUN, "latched fault without fault mode or reason")

	// Auto mode carries no reason and no latch
	`FMG_ASSERT_SAME(a_auto_clean, clk, arst_n, res_valid && res_mode == MODE_AUTO, res_reason == RSN_NONE && !res_fault, "auto mode with reason or fault")

	// Disabled mode only with a link or enable reason, or none after clear
	`FMG_ASSERT_SAME(a_dis_reason, clk, arst_n, res_valid && res_mode == MODE_DISABLED, res_reason == RSN_NONE || res_reason == RSN_NOLINK || res_reason == RSN_LINKLOST || res_reason == RSN_DISABLED, "disabled mode with a bad reason")

endmodule

bind failsafe_mode_gate_core fmg_checker u_fmg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_mode   (results.mode),
	.res_reason (results.reason),
	.res_fault  (results.fault_latched)
);
